/* design/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap queue: the heap entry,
// the operation codes and the sequencer states.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int KEY_W = 32;
   localparam int TAG_W = 16;
   localparam int CNT_W = 10;

   localparam logic [CNT_W-1:0] CAP_RESET = 10'd512;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_INS_RD   = 7'b0000010,
      ST_INS_CMP  = 7'b0000100,
      ST_DEL_LAST = 7'b0001000,
      ST_DEL_RD   = 7'b0010000,
      ST_DEL_CMP  = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

endpackage

/* design/bmhq_if.sv */
// ----------------------------------------------------------------------------
// bmhq request / response channels
// Valid/ready channels of the heap queue; a transaction moves at a rising
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] priority_req;
   logic [15:0] payload;

   modport source (output valid, opcode, priority_req, payload, input ready);
   modport sink   (input valid, opcode, priority_req, payload, output ready);
endinterface

interface bmhq_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic        nonempty;
   logic [31:0] best_priority;
   logic [15:0] best_payload;
   logic [9:0]  count;

   modport source (output valid, ok, nonempty, best_priority, best_payload, count,
                   input ready);
   modport sink   (input valid, ok, nonempty, best_priority, best_payload, count,
                   output ready);
endinterface

/* design/bmhq_mem.sv */
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap entry store: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmhq_mem #(
   parameter  int DEPTH = 512,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  bmhq_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output bmhq_pkg::entry_type rd_data_a,
   output bmhq_pkg::entry_type rd_data_b
);

   bmhq_pkg::entry_type mem_ff [DEPTH];
   bmhq_pkg::entry_type rd_a_ff;
   bmhq_pkg::entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* design/binary_min_heap_queue_unit.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// An insert moves its entry up at most 9 levels, a delete moves the last entry down
// at most 8. Refusals and deleting the only entry go straight to the response.
// One transaction at a time: a new request is taken only once the previous response
// has been loaded; a stalled response holds off the next request.
// Reset: synchronous; heap empties, capacity limit returns to 512, store
// content is left as is.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit #(
   parameter int DEPTH = 512
) (
   input  logic              clock,
   input  logic              reset,
   bmhq_req_if.sink          req_ch,
   bmhq_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [9:0]        csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = bmhq_pkg::CNT_W;

   // Sequencer state
   bmhq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;     // entries held
   logic [CW-1:0]       pos_ff, pos_in;       // 1-based heap position of hole
   bmhq_pkg::entry_type item_ff, item_in;     // entry being sifted
   bmhq_pkg::entry_type root_ff, root_in;     // copy of heap position 1
   logic                ok_ff, ok_in;
   logic [CW-1:0]       cap_ff;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic                rsp_ne_ff, rsp_ne_in;
   bmhq_pkg::entry_type rsp_best_ff, rsp_best_in;
   logic [CW-1:0]       rsp_cnt_ff, rsp_cnt_in;

   // Memory port
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   bmhq_pkg::entry_type mem_wdata;
   logic [AW-1:0]       mem_raddr_a;
   logic [AW-1:0]       mem_raddr_b;
   bmhq_pkg::entry_type mem_rdata_a;
   bmhq_pkg::entry_type mem_rdata_b;

   // Position arithmetic, all within CW bits since count never exceeds 1023
   logic [CW-1:0]       pos_m1;
   logic [CW-1:0]       pos_half;
   logic [CW-1:0]       left_pos;
   logic [CW-1:0]       right_pos;
   logic                is_full;
   logic                take_right;
   bmhq_pkg::entry_type child_ent;
   logic [CW-1:0]       child_pos;
   logic                req_fire;
   logic                rsp_load;

   assign pos_m1    = pos_ff - 10'd1;
   assign pos_half  = pos_ff >> 1;
   assign left_pos  = pos_ff << 1;
   assign right_pos = left_pos + 10'd1;

   // Effective limit is the smaller of the register and the store depth
   assign is_full = (fill_ff >= cap_ff) || (32'(fill_ff) >= DEPTH);

   // Right child wins a tie; it exists only when the left child is not last
   assign take_right = (left_pos != fill_ff) && (mem_rdata_a.key >= mem_rdata_b.key);
   assign child_ent  = take_right ? mem_rdata_b : mem_rdata_a;
   assign child_pos  = take_right ? right_pos : left_pos;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == bmhq_pkg::ST_IDLE);
   assign rsp_load     = (state_ff == bmhq_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   bmhq_mem #(.DEPTH(DEPTH)) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (mem_rdata_a),
      .rd_data_b (mem_rdata_b)
   );

   // Sift sequencer. Each level reads in one state and compares/writes back
   // in the next; the next read always targets another entry than the write,
   // and the write lands before that read is issued, so no forwarding is due.
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      item_in     = item_ff;
      ok_in       = ok_ff;
      mem_we      = 1'b0;
      mem_waddr   = AW'(pos_m1);
      mem_wdata   = item_ff;
      mem_raddr_a = AW'(left_pos - 10'd1);
      mem_raddr_b = AW'(left_pos);

      unique case (state_ff)
         bmhq_pkg::ST_IDLE: begin
            // Fetch the last entry ahead of a possible delete
            mem_raddr_a = AW'(fill_ff - 10'd1);
            if (req_fire) begin
               if (req_ch.opcode == bmhq_pkg::OP_INSERT) begin
                  if (is_full) begin
                     ok_in    = 1'b0;
                     state_in = bmhq_pkg::ST_DONE;
                  end else begin
                     ok_in         = 1'b1;
                     fill_in       = fill_ff + 10'd1;
                     pos_in        = fill_ff + 10'd1;
                     item_in.key   = req_ch.priority_req;
                     item_in.tag   = req_ch.payload;
                     state_in      = bmhq_pkg::ST_INS_RD;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     ok_in    = 1'b0;
                     state_in = bmhq_pkg::ST_DONE;
                  end else begin
                     ok_in    = 1'b1;
                     fill_in  = fill_ff - 10'd1;
                     pos_in   = 10'd1;
                     state_in = (fill_ff == 10'd1) ? bmhq_pkg::ST_DONE
                                                   : bmhq_pkg::ST_DEL_LAST;
                  end
               end
            end
         end

         bmhq_pkg::ST_INS_RD: begin
            if (pos_ff == 10'd1) begin
               mem_we   = 1'b1;
               state_in = bmhq_pkg::ST_DONE;
            end else begin
               mem_raddr_a = AW'(pos_half - 10'd1);
               state_in    = bmhq_pkg::ST_INS_CMP;
            end
         end

         bmhq_pkg::ST_INS_CMP: begin
            mem_we = 1'b1;
            if (item_ff.key < mem_rdata_a.key) begin
               // Move the parent down into the hole, walk up
               mem_wdata = mem_rdata_a;
               pos_in    = pos_half;
               state_in  = bmhq_pkg::ST_INS_RD;
            end else begin
               state_in  = bmhq_pkg::ST_DONE;
            end
         end

         bmhq_pkg::ST_DEL_LAST: begin
            item_in  = mem_rdata_a;
            state_in = bmhq_pkg::ST_DEL_RD;
         end

         bmhq_pkg::ST_DEL_RD: begin
            if (pos_ff > (fill_ff >> 1)) begin
               mem_we   = 1'b1;
               state_in = bmhq_pkg::ST_DONE;
            end else begin
               state_in = bmhq_pkg::ST_DEL_CMP;
            end
         end

         bmhq_pkg::ST_DEL_CMP: begin
            mem_we = 1'b1;
            if (item_ff.key > child_ent.key) begin
               // Move the smaller child up into the hole, walk down
               mem_wdata = child_ent;
               pos_in    = child_pos;
               state_in  = bmhq_pkg::ST_DEL_RD;
            end else begin
               state_in  = bmhq_pkg::ST_DONE;
            end
         end

         bmhq_pkg::ST_DONE: begin
            // Hold until the response register is free
            if (rsp_load) begin
               state_in = bmhq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bmhq_pkg::ST_IDLE;
         end
      endcase
   end

   // Track the root alongside every write to heap position 1
   always_comb begin
      root_in = root_ff;
      if (mem_we && (pos_ff == 10'd1)) begin
         root_in = mem_wdata;
      end
   end

   // Response register: load on completion, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_ne_in    = rsp_ne_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_ff;
         rsp_ne_in    = (fill_ff != '0);
         rsp_best_in  = (fill_ff != '0) ? root_ff : '0;
         rsp_cnt_in   = fill_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmhq_pkg::ST_IDLE;
         fill_ff      <= '0;
         cap_ff       <= bmhq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      item_ff     <= item_in;
      root_ff     <= root_in;
      ok_ff       <= ok_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_ne_ff   <= rsp_ne_in;
      rsp_best_ff <= rsp_best_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ok            = rsp_ok_ff;
   assign rsp_ch.nonempty      = rsp_ne_ff;
   assign rsp_ch.best_priority = rsp_best_ff.key;
   assign rsp_ch.best_payload  = rsp_best_ff.tag;
   assign rsp_ch.count         = rsp_cnt_ff;

endmodule

/* design/bmhq_checker.sv */
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic        rsp_nonempty,
   input logic [31:0] rsp_best_priority,
   input logic [15:0] rsp_best_payload,
   input logic [9:0]  rsp_count
);

   // A stalled response holds its content
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_count)
         && $stable(rsp_best_priority) && $stable(rsp_best_payload))
      else $error("stalled response changed");

   // One transaction in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // An empty heap reports zero count and zero root
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_nonempty |-> rsp_count == 10'd0 && rsp_best_priority == 32'd0
         && rsp_best_payload == 16'd0)
      else $error("empty heap response not cleared");

   // Nothing is offered right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && req_ready)
      else $error("response or busy state left over from reset");

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_ok            (rsp_ch.ok),
   .rsp_nonempty      (rsp_ch.nonempty),
   .rsp_best_priority (rsp_ch.best_priority),
   .rsp_best_payload  (rsp_ch.best_payload),
   .rsp_count         (rsp_ch.count)
);
